/* hdl/bkre_pkg.sv */
// bkre_pkg: shared types, constants and the usage-to-key-code table for the
// boot keyboard report to key event converter
// no dependencies
package bkre_pkg;

    // default number of key usage slots in one report
    localparam int KEY_SLOTS_DEF = 6;
    localparam int USAGE_W       = 8;
    localparam int CODE_W        = 7;

    // what one slot lane found for its new and its previous usage
    typedef struct packed {
        logic              press_hit;
        logic [CODE_W-1:0] press_code;
        logic              rel_hit;
        logic [CODE_W-1:0] rel_code;
    } t_lane_evt;

    // usage to set-1 key code, zero for unmapped usages
    function automatic logic [CODE_W-1:0] f_keymap(input logic [USAGE_W-1:0] usage);
        logic [CODE_W-1:0] code;
        case (usage)
            8'h04: code = 7'd30;
            8'h05: code = 7'd48;
            8'h06: code = 7'd46;
            8'h07: code = 7'd32;
            8'h08: code = 7'd18;
            8'h09: code = 7'd33;
            8'h0A: code = 7'd34;
            8'h0B: code = 7'd35;
            8'h0C: code = 7'd23;
            8'h0D: code = 7'd36;
            8'h0E: code = 7'd37;
            8'h0F: code = 7'd38;
            8'h10: code = 7'd50;
            8'h11: code = 7'd49;
            8'h12: code = 7'd24;
            8'h13: code = 7'd25;
            8'h14: code = 7'd16;
            8'h15: code = 7'd19;
            8'h16: code = 7'd31;
            8'h17: code = 7'd20;
            8'h18: code = 7'd22;
            8'h19: code = 7'd47;
            8'h1A: code = 7'd17;
            8'h1B: code = 7'd45;
            8'h1C: code = 7'd21;
            8'h1D: code = 7'd44;
            8'h1E: code = 7'd2;
            8'h1F: code = 7'd3;
            8'h20: code = 7'd4;
            8'h21: code = 7'd5;
            8'h22: code = 7'd6;
            8'h23: code = 7'd7;
            8'h24: code = 7'd8;
            8'h25: code = 7'd9;
            8'h26: code = 7'd10;
            8'h27: code = 7'd11;
            8'h28: code = 7'd28;
            8'h29: code = 7'd1;
            8'h2A: code = 7'd14;
            8'h2B: code = 7'd15;
            8'h2C: code = 7'd57;
            8'h3A: code = 7'd59;
            8'h3B: code = 7'd60;
            8'h3C: code = 7'd61;
            8'h3D: code = 7'd62;
            8'h3E: code = 7'd63;
            8'h3F: code = 7'd64;
            8'h40: code = 7'd65;
            8'h41: code = 7'd66;
            8'h42: code = 7'd67;
            8'h43: code = 7'd68;
            8'h44: code = 7'd87;
            8'h45: code = 7'd88;
            8'h4F: code = 7'd77;
            8'h50: code = 7'd75;
            8'h51: code = 7'd80;
            8'h52: code = 7'd72;
            8'hE0: code = 7'd29;
            8'hE1: code = 7'd42;
            8'hE2: code = 7'd56;
            8'hE4: code = 7'd97;
            8'hE5: code = 7'd54;
            8'hE6: code = 7'd100;
            default: code = '0;
        endcase
        return code;
    endfunction

endpackage

/* hdl/bkre_lane.sv */
// bkre_lane: one slot lane, checks its new and its previous usage against the
// other report and translates them
// depends on bkre_pkg
module bkre_lane #(
    parameter int KEY_SLOTS = bkre_pkg::KEY_SLOTS_DEF
) (
    input  logic [bkre_pkg::USAGE_W-1:0]                i_new_slot,
    input  logic [bkre_pkg::USAGE_W-1:0]                i_prev_slot,
    input  logic [KEY_SLOTS-1:0][bkre_pkg::USAGE_W-1:0] i_new_all,
    input  logic [KEY_SLOTS-1:0][bkre_pkg::USAGE_W-1:0] i_prev_all,
    output bkre_pkg::t_lane_evt                         o_evt
);
    import bkre_pkg::*;

    logic              new_held;
    logic              prev_kept;
    logic [CODE_W-1:0] new_code;
    logic [CODE_W-1:0] prev_code;

    // membership of the new usage in the old report and vice versa
    always_comb begin
        new_held  = 1'b0;
        prev_kept = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            if (i_prev_all[j] == i_new_slot) new_held = 1'b1;
            if (i_new_all[j] == i_prev_slot) prev_kept = 1'b1;
        end
    end

    // table lookups
    assign new_code  = f_keymap(i_new_slot);
    assign prev_code = f_keymap(i_prev_slot);

    // lane result
    always_comb begin
        o_evt.press_hit  = (i_new_slot != '0) && !new_held && (new_code != '0);
        o_evt.press_code = new_code;
        o_evt.rel_hit    = (i_prev_slot != '0) && !prev_kept && (prev_code != '0);
        o_evt.rel_code   = prev_code;
    end

endmodule

/* hdl/bkre_merge.sv */
// bkre_merge: collects the lane results of one report and hands the events out
// one per cycle while i_ev_ready allows, presses in slot order before releases
// depends on bkre_pkg
module bkre_merge #(
    parameter int KEY_SLOTS = bkre_pkg::KEY_SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  bkre_pkg::t_lane_evt [KEY_SLOTS-1:0] i_evt,
    output logic                                o_can_load,
    output logic                                o_ev_valid,
    input  logic                                i_ev_ready,
    output logic [bkre_pkg::CODE_W-1:0]         o_ev_code,
    output logic                                o_ev_press,
    output logic                                o_ev_last
);
    import bkre_pkg::*;

    localparam int EVTS = 2 * KEY_SLOTS;

    logic [EVTS-1:0]             r_pend_vld, n_pend_vld;
    logic [EVTS-1:0][CODE_W-1:0] r_pend_code, n_pend_code;
    logic                        r_out_vld, n_out_vld;
    logic [CODE_W-1:0]           r_out_code, n_out_code;
    logic                        r_out_press, n_out_press;
    logic                        r_out_last, n_out_last;

    logic                        out_load;
    logic [EVTS-1:0]             pick;
    logic [EVTS-1:0]             rest;
    logic [CODE_W-1:0]           pick_code;
    logic [EVTS-1:0]             evt_vld;
    logic [EVTS-1:0][CODE_W-1:0] evt_code;

    // lay the lanes out as presses first, then releases
    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            evt_vld[i]             = i_evt[i].press_hit;
            evt_code[i]            = i_evt[i].press_code;
            evt_vld[KEY_SLOTS+i]   = i_evt[i].rel_hit;
            evt_code[KEY_SLOTS+i]  = i_evt[i].rel_code;
        end
    end

    // lowest pending event and what is left behind it
    assign out_load = !r_out_vld || i_ev_ready;
    assign pick     = r_pend_vld & (~r_pend_vld + {{(EVTS-1){1'b0}}, 1'b1});
    assign rest     = r_pend_vld & ~pick;

    always_comb begin
        pick_code = '0;
        for (int j = 0; j < EVTS; j++) begin
            pick_code = pick_code | ({CODE_W{pick[j]}} & r_pend_code[j]);
        end
    end

    // a new report may enter once the pending events drain this cycle
    assign o_can_load = (r_pend_vld == '0) || ((rest == '0) && out_load);

    // next state of pending store and output register
    always_comb begin
        n_pend_vld  = r_pend_vld;
        n_pend_code = r_pend_code;
        n_out_vld   = r_out_vld;
        n_out_code  = r_out_code;
        n_out_press = r_out_press;
        n_out_last  = r_out_last;
        if (out_load) begin
            n_out_vld   = |r_pend_vld;
            n_out_code  = pick_code;
            n_out_press = |pick[KEY_SLOTS-1:0];
            n_out_last  = (rest == '0);
            n_pend_vld  = rest;
        end
        if (i_load) begin
            n_pend_vld  = evt_vld;
            n_pend_code = evt_code;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_pend_code <= n_pend_code;
        r_out_code  <= n_out_code;
        r_out_press <= n_out_press;
        r_out_last  <= n_out_last;
    end

    assign o_ev_valid = r_out_vld;
    assign o_ev_code  = r_out_code;
    assign o_ev_press = r_out_press;
    assign o_ev_last  = r_out_last;

endmodule

/* hdl/boot_keyboard_report_to_key_events.sv */
// The first event of a report goes from the pending store to the output register.
// A report yields N events (0 to 2*KEY_SLOTS), handed out by the single output register
// one per cycle while i_m_tready is high; the next report may enter as the last is loaded.
// Reset (synchronous, active low) clears the held report to all zero and drops
// every pending and presented event.
// Top level: slot lanes, held report register and event merge; uses bkre_pkg.
module boot_keyboard_report_to_key_events #(
    parameter int KEY_SLOTS = bkre_pkg::KEY_SLOTS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // slave side
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // fields from bit 0: slot_a, slot_b, ... one byte each
    input  logic [KEY_SLOTS*bkre_pkg::USAGE_W-1:0] i_s_tdata,
    // master side
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // fields from bit 0: scan_code (7), one zero pad bit
    output logic [7:0]                             o_m_tdata,
    // fields from bit 0: is_press
    output logic [0:0]                             o_m_tuser,
    // last_event
    output logic                                   o_m_tlast
);
    import bkre_pkg::*;

    logic [KEY_SLOTS-1:0][USAGE_W-1:0] r_prev, n_prev;
    logic [KEY_SLOTS-1:0][USAGE_W-1:0] new_slots;
    t_lane_evt [KEY_SLOTS-1:0]         lane_evt;
    logic                              accept;
    logic                              can_load;
    logic [CODE_W-1:0]                 ev_code;
    logic                              ev_press;

    assign new_slots  = i_s_tdata;
    assign o_s_tready = can_load;
    assign accept     = i_s_tvalid && can_load;

    // held report, replaced by every accepted request
    assign n_prev = accept ? new_slots : r_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else begin
            r_prev <= n_prev;
        end
    end

    // one lane per slot
    for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
        bkre_lane #(
            .KEY_SLOTS (KEY_SLOTS)
        ) u_lane (
            .i_new_slot  (new_slots[g]),
            .i_prev_slot (r_prev[g]),
            .i_new_all   (new_slots),
            .i_prev_all  (r_prev),
            .o_evt       (lane_evt[g])
        );
    end

    // ordering and hand-out of the events
    bkre_merge #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_evt      (lane_evt),
        .o_can_load (can_load),
        .o_ev_valid (o_m_tvalid),
        .i_ev_ready (i_m_tready),
        .o_ev_code  (ev_code),
        .o_ev_press (ev_press),
        .o_ev_last  (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, ev_code};
    assign o_m_tuser = ev_press;

endmodule

/* hdl/bkre_chk.sv */
// bkre_chk: port-level checks on the key event converter, bound to its top level
// depends on bkre_pkg and boot_keyboard_report_to_key_events
module bkre_chk #(
    parameter int KEY_SLOTS = bkre_pkg::KEY_SLOTS_DEF
) (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_s_tvalid,
    input logic                                   o_s_tready,
    input logic [KEY_SLOTS*bkre_pkg::USAGE_W-1:0] i_s_tdata,
    input logic                                   o_m_tvalid,
    input logic                                   i_m_tready,
    input logic [7:0]                             o_m_tdata,
    input logic [0:0]                             o_m_tuser,
    input logic                                   o_m_tlast
);

    // a waiting request keeps its report
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && !o_s_tready |=> i_s_tvalid && $stable(i_s_tdata))
        else $error("waiting request changed");

    // stalled event holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled event changed");

    // every event carries a mapped code and a zero pad bit
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[7] == 1'b0) && (o_m_tdata[6:0] != 7'd0))
        else $error("event with empty or oversized key code");

    // events of one report leave back to back
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tvalid)
        else $error("gap inside the events of one report");

    // reset drops the presented event
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("event presented right after reset");

endmodule

bind boot_keyboard_report_to_key_events bkre_chk #(.KEY_SLOTS(KEY_SLOTS)) u_bkre_chk (.*);
